// ----- hdl/pig_pkg.sv -----
// ----------------------------------------------------------------------------
// pig_pkg
// Shared constants and controller/datapath interface types for the
// primitive index generator.
// ----------------------------------------------------------------------------
`default_nettype none

package pig_pkg;

  localparam int IDX_W       = 16;
  localparam int MAX_PATTERN = 8;
  localparam int ENTRY_W     = 16;
  localparam int CNT_W       = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 4;
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 16;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_STRIDE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JOIN_MODE      = 3'd4;

  // reset values: pattern {0,2,1,2,3,1,0,0}, length 6, stride 4, plain joins
  localparam logic [CFG_DATA_W-1:0] RST_PATTERN_LOW    = 64'h0002_0001_0002_0000;
  localparam logic [CFG_DATA_W-1:0] RST_PATTERN_HIGH   = 64'h0000_0000_0001_0003;
  localparam logic [LEN_W-1:0]      RST_PATTERN_LENGTH = 4'd6;
  localparam logic [ENTRY_W-1:0]    RST_VERTEX_STRIDE  = 16'd4;

  typedef struct packed {
    logic start;       // capture a new primitive
    logic emit_pat;    // emit the current pattern index
    logic emit_join0;  // emit the repeated final index
    logic emit_join1;  // emit the next primitive's first index
  } pig_cmd_t;

  typedef struct packed {
    logic can_emit;    // output register free or being drained
    logic last_entry;  // pattern counter at the final entry
    logic joins;       // this primitive is followed by join indices
  } pig_sts_t;

endpackage

`default_nettype wire

// ----- hdl/pig_ctrl.sv -----
// ----------------------------------------------------------------------------
// pig_ctrl
// Sequencer for one primitive: pattern indices, then optional join indices.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_ctrl
  import pig_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_tvalid,
  output logic          in_tready,
  input  wire pig_sts_t sts,
  output pig_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_PAT   = 4'b0010,
    ST_JOIN0 = 4'b0100,
    ST_JOIN1 = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          state_nxt = ST_PAT;
        end
      end
      ST_PAT: begin
        if (sts.can_emit) begin
          cmd.emit_pat = 1'b1;
          if (sts.last_entry) begin
            state_nxt = sts.joins ? ST_JOIN0 : ST_IDLE;
          end
        end
      end
      ST_JOIN0: begin
        if (sts.can_emit) begin
          cmd.emit_join0 = 1'b1;
          state_nxt      = ST_JOIN1;
        end
      end
      ST_JOIN1: begin
        if (sts.can_emit) begin
          cmd.emit_join1 = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/pig_datapath.sv -----
// ----------------------------------------------------------------------------
// pig_datapath
// Configuration registers, vertex base, pattern counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pig_datapath
  import pig_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_valid,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_first,
  input  wire logic                   in_last,
  input  wire pig_cmd_t               cmd,
  output pig_sts_t                    sts,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [IDX_W-1:0]            out_index,
  output logic                        out_join,
  output logic                        out_last
);

  logic [CFG_DATA_W-1:0] pat_low_r, pat_high_r;
  logic [LEN_W-1:0]      len_r;
  logic [ENTRY_W-1:0]    stride_r;
  logic                  join_mode_r;

  logic [IDX_W-1:0]      base_r, last_idx_r, out_index_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  joins_r, out_valid_r, out_join_r, out_last_r;

  logic [2*CFG_DATA_W-1:0] pat_all;
  logic [CNT_W-1:0]        len_m1;
  logic [IDX_W-1:0]        entry_cur, entry_first, pat_idx, join_idx, base_adv;
  logic                    last_entry;
  logic                    emit_any;

  assign pat_all = {pat_high_r, pat_low_r};

  // saturate length into 1..MAX_PATTERN
  always_comb begin
    if (len_r == '0) begin
      len_m1 = '0;
    end else if (len_r > LEN_W'(MAX_PATTERN)) begin
      len_m1 = CNT_W'(MAX_PATTERN - 1);
    end else begin
      len_m1 = CNT_W'(len_r - LEN_W'(1));
    end
  end

  assign entry_cur   = IDX_W'(pat_all[cnt_r*ENTRY_W +: ENTRY_W]);
  assign entry_first = IDX_W'(pat_all[ENTRY_W-1:0]);
  assign pat_idx     = entry_cur + base_r;
  assign join_idx    = entry_first + base_r;  // base already advanced here
  assign base_adv    = base_r + IDX_W'(stride_r);
  assign last_entry  = (cnt_r == len_m1);
  assign emit_any    = cmd.emit_pat | cmd.emit_join0 | cmd.emit_join1;

  assign sts.can_emit   = !out_valid_r || out_tready;
  assign sts.last_entry = last_entry;
  assign sts.joins      = joins_r;

  // configuration decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_low_r   <= RST_PATTERN_LOW;
      pat_high_r  <= RST_PATTERN_HIGH;
      len_r       <= RST_PATTERN_LENGTH;
      stride_r    <= RST_VERTEX_STRIDE;
      join_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LOW:    pat_low_r   <= cfg_data;
        REG_PATTERN_HIGH:   pat_high_r  <= cfg_data;
        REG_PATTERN_LENGTH: len_r       <= cfg_data[LEN_W-1:0];
        REG_VERTEX_STRIDE:  stride_r    <= cfg_data[ENTRY_W-1:0];
        REG_JOIN_MODE:      join_mode_r <= cfg_data[0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  // sequencing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      cnt_r       <= '0;
      joins_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.start) begin
        if (in_first) begin
          base_r <= '0;
        end
        cnt_r   <= '0;
        joins_r <= join_mode_r & ~in_last;
      end else if (cmd.emit_pat) begin
        if (last_entry) begin
          base_r <= base_adv;
          cnt_r  <= '0;
        end else begin
          cnt_r <= cnt_r + CNT_W'(1);
        end
      end
      if (emit_any) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (cmd.emit_pat) begin
      out_index_r <= pat_idx;
      out_join_r  <= 1'b0;
      out_last_r  <= last_entry & ~joins_r;
      last_idx_r  <= pat_idx;
    end else if (cmd.emit_join0) begin
      out_index_r <= last_idx_r;
      out_join_r  <= 1'b1;
      out_last_r  <= 1'b0;
    end else if (cmd.emit_join1) begin
      out_index_r <= join_idx;
      out_join_r  <= 1'b1;
      out_last_r  <= 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_index  = out_index_r;
  assign out_join   = out_join_r;
  assign out_last   = out_last_r;

endmodule

`default_nettype wire

// ----- hdl/primitive_index_generator_core.sv -----
// ----------------------------------------------------------------------------
// primitive_index_generator_core
// Emits the configured index pattern plus a running vertex base per primitive,
// with optional degenerate-strip join indices between primitives.
// ----------------------------------------------------------------------------
// An accepted primitive's indices pass through the shared output register, one index
// per cycle while out_tready does not stall it; the next primitive is accepted only
// after the last index of the current one has been loaded into that register.
// Reset (synchronous, rst_n low): registers return to their default pattern,
// length 6, stride 4, plain mode; vertex base cleared, output empty.
`default_nettype none

module primitive_index_generator_core
  import pig_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // configuration write channel
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  // primitive input
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // [0] first_primitive, rest zero
  input  wire logic                   in_tlast,   // last_primitive
  // index output
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // [15:0] index_value
  output logic                        out_tuser,  // is_join
  output logic                        out_tlast   // last_of_run
);

  pig_cmd_t         cmd;
  pig_sts_t         sts;
  logic [IDX_W-1:0] index_val;

  assign cfg_ready = 1'b1;

  pig_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  pig_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_first   (in_tdata[0]),
    .in_last    (in_tlast),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_index  (index_val),
    .out_join   (out_tuser),
    .out_last   (out_tlast)
  );

  assign out_tdata = OUT_TDATA_W'(index_val);

endmodule

`default_nettype wire

// ----- test/pig_index_checker.sv -----
// ----------------------------------------------------------------------------
// pig_index_checker
// Watches the configuration, primitive and index channels of the primitive
// index generator, predicts the index stream for every accepted primitive
// and compares each accepted index with the oldest prediction.
// ----------------------------------------------------------------------------
module pig_index_checker
  import pig_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,   // [0] first_primitive
  input  logic                  in_tlast,   // last_primitive
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata, // [15:0] index_value
  input  logic                  out_tuser,  // is_join
  input  logic                  out_tlast,  // last_of_run
  output int                    error_count,
  output int                    pending_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] value;
    logic             is_join;
    logic             run_end;
  } index_item_t;

  index_item_t expected_indices[$];

  logic [CFG_DATA_W-1:0] pat_lo;
  logic [CFG_DATA_W-1:0] pat_hi;
  logic [LEN_W-1:0]      pat_len;
  logic [ENTRY_W-1:0]    stride;
  logic                  join_en;
  logic [IDX_W-1:0]      vertex_base;

  initial begin
    error_count   = 0;
    pending_count = 0;
  end

  function automatic logic [ENTRY_W-1:0] pattern_entry(input int k);
    logic [CFG_DATA_W-1:0] word;
    word = (k < 4) ? pat_lo : pat_hi;
    return word[ENTRY_W*(k%4) +: ENTRY_W];
  endfunction

  task automatic predict_indices(input logic first_prim, input logic last_prim);
    int               len;
    logic             joins;
    logic [IDX_W-1:0] base_now;
    logic [IDX_W-1:0] next_base;
    logic [IDX_W-1:0] value;
    index_item_t      item;
    len = int'(pat_len);
    if (len < 1) len = 1;
    if (len > MAX_PATTERN) len = MAX_PATTERN;
    if (first_prim) vertex_base = '0;
    base_now  = vertex_base;
    next_base = base_now + stride;
    joins     = join_en && !last_prim;
    value     = '0;
    for (int k = 0; k < len; k++) begin
      value        = pattern_entry(k) + base_now;
      item.value   = value;
      item.is_join = 1'b0;
      item.run_end = (k == len - 1) && !joins;
      expected_indices.push_back(item);
    end
    if (joins) begin
      // repeat the closing index, then step into the next primitive
      item = '{value: value, is_join: 1'b1, run_end: 1'b0};
      expected_indices.push_back(item);
      item = '{value: pattern_entry(0) + next_base, is_join: 1'b1, run_end: 1'b1};
      expected_indices.push_back(item);
    end
    vertex_base = next_base;
  endtask

  always @(posedge clk) begin
    index_item_t want;
    if (!rst_n) begin
      pat_lo      = RST_PATTERN_LOW;
      pat_hi      = RST_PATTERN_HIGH;
      pat_len     = RST_PATTERN_LENGTH;
      stride      = RST_VERTEX_STRIDE;
      join_en     = 1'b0;
      vertex_base = '0;
      expected_indices.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PATTERN_LOW:    pat_lo  = cfg_data;
          REG_PATTERN_HIGH:   pat_hi  = cfg_data;
          REG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          REG_VERTEX_STRIDE:  stride  = cfg_data[ENTRY_W-1:0];
          REG_JOIN_MODE:      join_en = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_indices(in_tdata[0], in_tlast);
      if (out_tvalid && out_tready) begin
        if (expected_indices.size() == 0) begin
          $display("%0t: unexpected index: idx=%h join=%b last=%b",
                   $time, out_tdata[IDX_W-1:0], out_tuser, out_tlast);
          error_count++;
        end else begin
          want = expected_indices.pop_front();
          if (out_tdata[IDX_W-1:0] !== want.value || out_tuser !== want.is_join ||
              out_tlast !== want.run_end) begin
            $display("%0t: index mismatch: expected idx=%h join=%b last=%b, got idx=%h join=%b last=%b",
                     $time, want.value, want.is_join, want.run_end,
                     out_tdata[IDX_W-1:0], out_tuser, out_tlast);
            error_count++;
          end
        end
      end
    end
    pending_count = expected_indices.size();
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Drives primitives and register writes into the primitive index generator
// under several idling patterns, with one long output hold-off, and gives the
// verdict from the index checker's error and pending counts.
// ----------------------------------------------------------------------------
module tb_top;
  import pig_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_LIMIT   = 20000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES   = 250;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = REG_JOIN_MODE + 1'b1;

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // [0] first_primitive, rest zero
  logic                   in_tlast;   // last_primitive
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // [15:0] index_value
  logic                   out_tuser;  // is_join
  logic                   out_tlast;  // last_of_run

  int error_count;
  int pending_count;
  int send_idle_pct;
  int stall_pct;
  bit hold_off_req;

  primitive_index_generator_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  pig_index_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .error_count   (error_count),
    .pending_count (pending_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // index receiver: random stalls, plus one long hold-off on request
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off_req = 1'b0;
      end
      out_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_prim(input logic first_prim, input logic last_prim);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-1){1'b0}}, first_prim};
    in_tlast  <= last_prim;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop the input and wait for every predicted index to drain
  task automatic settle();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    // let the checker take in the last accepted item first
    @(posedge clk);
    while (pending_count != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] junk_above(input int keep,
                                                       input logic [CFG_DATA_W-1:0] low);
    logic [CFG_DATA_W-1:0] r;
    r = {$urandom, $urandom};
    return (r << keep) | (low & ((64'd1 << keep) - 1));
  endfunction

  task automatic random_setting();
    logic [CFG_DATA_W-1:0] lo;
    logic [CFG_DATA_W-1:0] hi;
    int len;
    int pick;
    pick = $urandom_range(5);
    lo = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
    pick = $urandom_range(5);
    hi = (pick == 0) ? '1 : (pick == 1) ? '0 : {$urandom, $urandom};
    len = $urandom_range(9);
    len = (len < 8) ? len + 1 : $urandom_range(15);
    write_reg(REG_PATTERN_LOW, lo);
    write_reg(REG_PATTERN_HIGH, hi);
    write_reg(REG_PATTERN_LENGTH, junk_above(LEN_W, len));
    pick = $urandom_range(4);
    write_reg(REG_VERTEX_STRIDE, junk_above(ENTRY_W,
              (pick == 0) ? 16'hFFFF : (pick == 1) ? 16'h0000 :
              (pick == 2) ? $urandom_range(16) : $urandom_range(16'hFFFF)));
    write_reg(REG_JOIN_MODE, junk_above(1, $urandom_range(1)));
    if ($urandom_range(3) == 0)
      write_reg(CFG_IDX_W'(REG_UNMAPPED_LO + $urandom_range(2)), {$urandom, $urandom});
  endtask

  task automatic random_batches(input int count);
    int n;
    while (count > 0) begin
      if ($urandom_range(9) == 0) begin
        send_prim($urandom_range(1), $urandom_range(1));
        count--;
      end else begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) send_prim(i == 0, i == n - 1);
        count -= n;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_off_req  = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default pattern, base running from reset without a first flag
    send_prim(1'b0, 1'b0);
    send_prim(1'b0, 1'b0);
    send_prim(1'b1, 1'b0);
    send_prim(1'b0, 1'b1);
    send_prim(1'b1, 1'b1);
    settle();

    // all-ones low words, edge values in the high words, full length, widest stride: additions wrap
    write_reg(REG_PATTERN_LOW, '1);
    write_reg(REG_PATTERN_HIGH, 64'hFFFF_8000_0001_0000);
    write_reg(REG_PATTERN_LENGTH, 64'd8);
    write_reg(REG_VERTEX_STRIDE, 64'hFFFF);
    write_reg(REG_JOIN_MODE, 64'd1);
    send_prim(1'b1, 1'b0);
    send_prim(1'b0, 1'b0);
    send_prim(1'b0, 1'b1);
    send_prim(1'b1, 1'b1);
    settle();

    // zero length acts as one entry; high data bits are dropped
    write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFF0);
    write_reg(REG_VERTEX_STRIDE, 64'hFFFF_FFFF_FFFF_0000);
    send_prim(1'b1, 1'b0);
    send_prim(1'b0, 1'b0);
    send_prim(1'b0, 1'b1);
    settle();

    // oversized length saturates; writes past the register list are ignored
    write_reg(REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_JOIN_MODE, 64'hFFFF_FFFF_FFFF_FFFE);
    for (int u = 0; u < 3; u++) write_reg(CFG_IDX_W'(REG_UNMAPPED_LO + u), '1);
    write_reg(REG_PATTERN_LOW, '0);
    send_prim(1'b0, 1'b0);
    send_prim(1'b1, 1'b1);
    settle();

    write_reg(REG_PATTERN_LENGTH, 64'd1);
    write_reg(REG_VERTEX_STRIDE, 64'd1);
    write_reg(REG_JOIN_MODE, 64'd1);
    send_prim(1'b1, 1'b0);
    send_prim(1'b0, 1'b1);
    settle();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 69; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 69; end
        default: begin send_idle_pct = 29; stall_pct = 29; end
      endcase
      for (int s = 0; s < 4; s++) begin
        random_setting();
        // hold the output back so the block fills and pushes back
        if (phase == 0 && s == 1) hold_off_req = 1'b1;
        random_batches(17);
        settle();
      end
    end

    if (error_count == 0 && pending_count == 0) begin
      $display("RESULT: OK");
    end else begin
      if (pending_count != 0)
        $display("%0t: %0d expected indices never arrived", $time, pending_count);
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
